// ----- hdl/teq_pkg.sv -----
package teq_pkg;
   localparam int QUEUE_DEPTH = 64;
   localparam int TIME_BITS = 48;
   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [1:0] CMD_CANCEL   = 2'd1;
   localparam logic [1:0] CMD_NEXT     = 2'd2;
   localparam logic [1:0] CMD_CLEAR    = 2'd3;

   localparam logic [2:0] OUT_SCHEDULED = 3'd0;
   localparam logic [2:0] OUT_CANCELLED = 3'd1;
   localparam logic [2:0] OUT_NOT_FOUND = 3'd2;
   localparam logic [2:0] OUT_DISPATCHED = 3'd3;
   localparam logic [2:0] OUT_DROPPED = 3'd4;
   localparam logic [2:0] OUT_EMPTY = 3'd5;
   localparam logic [2:0] OUT_FULL = 3'd6;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;        // capture the request
      logic scan_start;  // begin a slot scan
      logic scan_step;   // advance scan by one slot
      logic finish;      // apply the command and build the result
   } ctrl_type;

   typedef struct packed {
      logic scan_done;
   } stat_type;
endpackage

// ----- hdl/teq_datapath.sv -----
module teq_datapath (
   input  logic clock,
   input  logic reset,
   input  teq_pkg::ctrl_type ctrl,
   output teq_pkg::stat_type stat,
   input  logic [1:0] req_command,
   input  logic [47:0] req_event_time,
   input  logic [47:0] req_begin_time,
   input  logic req_duration_negative,
   input  logic [15:0] req_action_tag,
   input  logic [31:0] req_cancel_id,
   output logic [2:0] rsp_outcome,
   output logic [31:0] rsp_entry_id,
   output logic [15:0] rsp_entry_tag,
   output logic [47:0] rsp_entry_time,
   output logic [47:0] rsp_now_time,
   output logic rsp_warn_past,
   output logic rsp_warn_negative,
   output logic rsp_warn_no_actor
);
   import teq_pkg::*;

   // Entries sit unordered in slots; order comes from time then sequence number.
   logic [TIME_BITS-1:0] mem_time [QUEUE_DEPTH];
   logic [31:0] mem_id [QUEUE_DEPTH];
   logic [15:0] mem_tag [QUEUE_DEPTH];
   logic [31:0] mem_seq [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] valid_ff;

   logic [1:0] cmd_ff;
   logic [TIME_BITS-1:0] etime_ff, btime_ff, now_ff;
   logic neg_ff;
   logic [15:0] tag_ff;
   logic [31:0] want_ff, next_id_ff, seq_ff;

   logic [IDX_BITS:0] scan_ff;     // issue index, extra bit marks end
   logic rd_valid_ff;
   logic [IDX_BITS-1:0] rd_idx_ff;
   logic [TIME_BITS-1:0] rd_time_ff;
   logic [31:0] rd_id_ff, rd_seq_ff;
   logic [15:0] rd_tag_ff;
   logic rd_live_ff;

   logic found_ff;
   logic [IDX_BITS-1:0] best_idx_ff, free_idx_ff;
   logic free_found_ff;
   logic [TIME_BITS-1:0] best_time_ff;
   logic [31:0] best_id_ff, best_seq_ff;
   logic [15:0] best_tag_ff;

   logic take;
   always_comb begin
      take = 1'b0;
      if (rd_valid_ff && rd_live_ff) begin
         if (cmd_ff == CMD_CANCEL) begin
            take = !found_ff && (rd_id_ff == want_ff) &&
                   (!found_ff || rd_seq_ff < best_seq_ff);
         end else begin
            take = !found_ff || rd_time_ff < best_time_ff ||
                   (rd_time_ff == best_time_ff && rd_seq_ff < best_seq_ff);
         end
      end
   end

   // Cancel takes the first match in queue order, so compare time and then sequence.
   logic take_cancel;
   always_comb begin
      take_cancel = rd_valid_ff && rd_live_ff && (rd_id_ff == want_ff) &&
                    (!found_ff || rd_time_ff < best_time_ff ||
                     (rd_time_ff == best_time_ff && rd_seq_ff < best_seq_ff));
   end

   assign stat.scan_done = scan_ff[IDX_BITS] && !rd_valid_ff;

   always_ff @(posedge clock) begin
      rd_time_ff <= mem_time[scan_ff[IDX_BITS-1:0]];
      rd_id_ff <= mem_id[scan_ff[IDX_BITS-1:0]];
      rd_tag_ff <= mem_tag[scan_ff[IDX_BITS-1:0]];
      rd_seq_ff <= mem_seq[scan_ff[IDX_BITS-1:0]];
      rd_live_ff <= valid_ff[scan_ff[IDX_BITS-1:0]];
      rd_idx_ff <= scan_ff[IDX_BITS-1:0];
      if (ctrl.finish && cmd_ff == CMD_SCHEDULE && free_found_ff) begin
         mem_time[free_idx_ff] <= etime_ff;
         mem_id[free_idx_ff] <= next_id_ff;
         mem_tag[free_idx_ff] <= tag_ff;
         mem_seq[free_idx_ff] <= seq_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         next_id_ff <= 32'd1;
         now_ff <= '0;
         seq_ff <= '0;
         scan_ff <= '0;
         rd_valid_ff <= 1'b0;
         found_ff <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         if (ctrl.load) begin
            cmd_ff <= req_command;
            etime_ff <= req_event_time;
            btime_ff <= req_begin_time;
            neg_ff <= req_duration_negative;
            tag_ff <= req_action_tag;
            want_ff <= req_cancel_id;
         end
         if (ctrl.scan_start) begin
            scan_ff <= '0;
            rd_valid_ff <= 1'b0;
            found_ff <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (ctrl.scan_step) begin
            rd_valid_ff <= !scan_ff[IDX_BITS];
            if (!scan_ff[IDX_BITS]) begin
               scan_ff <= scan_ff + 1'b1;
            end
            if (rd_valid_ff && !rd_live_ff && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff <= rd_idx_ff;
            end
            if ((cmd_ff == CMD_CANCEL) ? take_cancel : take) begin
               found_ff <= 1'b1;
               best_idx_ff <= rd_idx_ff;
               best_time_ff <= rd_time_ff;
               best_id_ff <= rd_id_ff;
               best_tag_ff <= rd_tag_ff;
               best_seq_ff <= rd_seq_ff;
            end
         end
         if (ctrl.finish) begin
            rsp_outcome <= OUT_EMPTY;
            rsp_entry_id <= '0;
            rsp_entry_tag <= '0;
            rsp_entry_time <= '0;
            rsp_warn_past <= 1'b0;
            rsp_warn_negative <= 1'b0;
            rsp_warn_no_actor <= 1'b0;
            rsp_now_time <= now_ff;
            case (cmd_ff)
               CMD_SCHEDULE: begin
                  rsp_warn_past <= (btime_ff < now_ff) || (etime_ff < now_ff);
                  rsp_warn_negative <= neg_ff;
                  rsp_warn_no_actor <= (tag_ff == 16'd0);
                  if (free_found_ff) begin
                     valid_ff[free_idx_ff] <= 1'b1;
                     rsp_outcome <= OUT_SCHEDULED;
                     rsp_entry_id <= next_id_ff;
                     next_id_ff <= next_id_ff + 32'd1;
                     seq_ff <= seq_ff + 32'd1;
                  end else begin
                     rsp_outcome <= OUT_FULL;
                  end
               end
               CMD_CANCEL: begin
                  if (found_ff) begin
                     valid_ff[best_idx_ff] <= 1'b0;
                     rsp_outcome <= OUT_CANCELLED;
                     rsp_entry_id <= want_ff;
                  end else begin
                     rsp_outcome <= OUT_NOT_FOUND;
                  end
               end
               CMD_NEXT: begin
                  if (found_ff) begin
                     valid_ff[best_idx_ff] <= 1'b0;
                     rsp_entry_id <= best_id_ff;
                     rsp_entry_tag <= best_tag_ff;
                     rsp_entry_time <= best_time_ff;
                     if (best_time_ff < now_ff) begin
                        rsp_outcome <= OUT_DROPPED;
                     end else begin
                        rsp_outcome <= OUT_DISPATCHED;
                        now_ff <= best_time_ff;
                        rsp_now_time <= best_time_ff;
                     end
                  end
               end
               default: begin
                  valid_ff <= '0;
                  next_id_ff <= 32'd1;
               end
            endcase
         end
      end
   end
endmodule

// ----- hdl/teq_control.sv -----
module teq_control (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output teq_pkg::ctrl_type ctrl,
   input  teq_pkg::stat_type stat
);
   import teq_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_START, S_SCAN, S_OUT} state_type;
   state_type state_ff;
   logic rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctrl = '0;
      ctrl.load = req_valid && req_ready;
      ctrl.scan_start = (state_ff == S_START);
      ctrl.scan_step = (state_ff == S_SCAN);
      ctrl.finish = (state_ff == S_SCAN) && stat.scan_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (req_valid) state_ff <= S_START;
            S_START: state_ff <= S_SCAN;
            S_SCAN: begin
               if (stat.scan_done) begin
                  state_ff <= S_OUT;
                  rsp_valid_ff <= 1'b1;
               end
            end
            S_OUT: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- hdl/timed_event_queue_unit.sv -----
// Timed event queue: one command in flight at a time.
// Every command runs a scan that reads one slot memory entry per cycle,
// and the result is registered when that scan is done.
// A new request is taken only once the previous result has been accepted.
// Reset: queue empty, current time 0, id counter 1; no clearing pass is needed.
module timed_event_queue_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_command,
   input  logic [47:0] req_event_time,
   input  logic [47:0] req_begin_time,
   input  logic req_duration_negative,
   input  logic [15:0] req_action_tag,
   input  logic [31:0] req_cancel_id,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [2:0] rsp_outcome,
   output logic [31:0] rsp_entry_id,
   output logic [15:0] rsp_entry_tag,
   output logic [47:0] rsp_entry_time,
   output logic [47:0] rsp_now_time,
   output logic rsp_warn_past,
   output logic rsp_warn_negative,
   output logic rsp_warn_no_actor
);
   import teq_pkg::*;

   ctrl_type ctrl;
   stat_type stat;

   teq_control u_control (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .ctrl(ctrl), .stat(stat)
   );

   teq_datapath u_datapath (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat),
      .req_command(req_command), .req_event_time(req_event_time),
      .req_begin_time(req_begin_time), .req_duration_negative(req_duration_negative),
      .req_action_tag(req_action_tag), .req_cancel_id(req_cancel_id),
      .rsp_outcome(rsp_outcome), .rsp_entry_id(rsp_entry_id),
      .rsp_entry_tag(rsp_entry_tag), .rsp_entry_time(rsp_entry_time),
      .rsp_now_time(rsp_now_time), .rsp_warn_past(rsp_warn_past),
      .rsp_warn_negative(rsp_warn_negative), .rsp_warn_no_actor(rsp_warn_no_actor)
   );
endmodule
